// ===== design/tmtw_pkg.sv =====
package tmtw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = $clog2(CELL_COUNT);

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [7:0]  SPACE_CODE   = 8'd32;
  localparam logic [7:0]  RESET_COLOR  = 8'd7;
  localparam logic [15:0] RESET_CELL   = {RESET_COLOR, SPACE_CODE};

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_FILL,
    S_BLANK
  } state_t;

  // logical row to physical row of the rotating screen
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, r} + {1'b0, top};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

endpackage

// ===== design/text_mode_terminal_writer.sv =====
// text-mode terminal writer: a rows x columns screen of 16-bit cells (attribute in
// 15..8, character in 7..0) plus a cursor, kept in one synchronous memory.
// a command word is taken at a clock edge where start is high and busy is low; its
// result word appears for exactly one cycle with done high and cannot be held off,
// so the receiver must take it then. all cell writes share the single memory write port:
// a put of a character writes one cell, a read goes through the registered memory read,
// a put or newline that scrolls also blanks a row, and a clear writes every cell. scrolling does not
// move data: the screen is a ring of rows with a top-row pointer, so a scroll only
// blanks one row. after reset the block runs a clearing pass over every cell
// with busy high; text_color writes are taken during that pass
module text_mode_terminal_writer (
  input  logic                       clk,
  input  logic                       rst,
  // command side
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 command,
  input  logic [7:0]                 char_code,
  input  logic [tmtw_pkg::ROW_W-1:0] read_row,
  input  logic [tmtw_pkg::COL_W-1:0] read_col,
  // color register
  input  logic                       text_color_we,
  input  logic [7:0]                 text_color,
  // result side
  output logic                       done,
  output logic [tmtw_pkg::COL_W-1:0] cursor_col_out,
  output logic [tmtw_pkg::ROW_W-1:0] cursor_row_out,
  output logic [15:0]                cell_entry
);

  tmtw_pkg::state_t state, state_next;

  // latched command word
  logic [1:0]                  cmd;
  logic [7:0]                  char_q;
  logic [tmtw_pkg::ROW_W-1:0]  rrow;
  logic [tmtw_pkg::COL_W-1:0]  rcol;
  logic                        rd_ok;

  // cursor and ring pointer
  logic [tmtw_pkg::COL_W-1:0]  cur_col, cur_col_next;
  logic [tmtw_pkg::ROW_W-1:0]  cur_row, cur_row_next;
  logic [tmtw_pkg::ROW_W-1:0]  top, top_next;
  logic [tmtw_pkg::ROW_W-1:0]  blank_row, blank_row_next;

  // sweep counter for blank and fill passes
  logic [tmtw_pkg::ADDR_W-1:0] cnt, cnt_next;
  logic [7:0]                  color;

  // screen memory
  logic [15:0]                 cells [tmtw_pkg::CELL_COUNT];
  logic                        mem_we;
  logic [tmtw_pkg::ADDR_W-1:0] mem_waddr;
  logic [15:0]                 mem_wdata;
  logic [tmtw_pkg::ADDR_W-1:0] mem_raddr;
  logic [15:0]                 mem_rdata;

  logic                        accept;
  logic                        is_nl;
  logic                        wrap;
  logic                        last_row;
  logic                        fill_last;
  logic                        blank_last;
  logic                        emit;
  logic [15:0]                 cell_val;

  assign busy       = (state != tmtw_pkg::S_IDLE);
  assign accept     = start && !busy;
  assign is_nl      = (char_q == tmtw_pkg::NEWLINE_CODE);
  // newline, or the put lands on the last column
  assign wrap       = is_nl || (cur_col == tmtw_pkg::COL_W'(tmtw_pkg::COLUMNS - 1));
  assign last_row   = (cur_row == tmtw_pkg::ROW_W'(tmtw_pkg::ROWS - 1));
  assign fill_last  = (cnt == tmtw_pkg::ADDR_W'(tmtw_pkg::CELL_COUNT - 1));
  assign blank_last = (cnt == tmtw_pkg::ADDR_W'(tmtw_pkg::COLUMNS - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tmtw_pkg::S_INIT: begin
        if (fill_last) begin
          state_next = tmtw_pkg::S_IDLE;
        end
      end
      tmtw_pkg::S_IDLE: begin
        if (accept) begin
          state_next = tmtw_pkg::S_EXEC;
        end
      end
      tmtw_pkg::S_EXEC: begin
        case (cmd)
          tmtw_pkg::CMD_PUT: begin
            if (wrap && last_row) begin
              state_next = tmtw_pkg::S_BLANK;
            end else begin
              state_next = tmtw_pkg::S_IDLE;
            end
          end
          tmtw_pkg::CMD_READ:  state_next = tmtw_pkg::S_READ;
          tmtw_pkg::CMD_CLEAR: state_next = tmtw_pkg::S_FILL;
          default:             state_next = tmtw_pkg::S_IDLE;
        endcase
      end
      tmtw_pkg::S_READ: state_next = tmtw_pkg::S_IDLE;
      tmtw_pkg::S_FILL: begin
        if (fill_last) begin
          state_next = tmtw_pkg::S_IDLE;
        end
      end
      tmtw_pkg::S_BLANK: begin
        if (blank_last) begin
          state_next = tmtw_pkg::S_IDLE;
        end
      end
      default: state_next = tmtw_pkg::S_INIT;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cur_col_next   = cur_col;
    cur_row_next   = cur_row;
    top_next       = top;
    blank_row_next = blank_row;
    cnt_next       = cnt;
    mem_we         = 1'b0;
    mem_waddr      = cnt;
    mem_wdata      = {color, tmtw_pkg::SPACE_CODE};
    mem_raddr      = '0;
    emit           = 1'b0;
    case (state)
      tmtw_pkg::S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = tmtw_pkg::RESET_CELL;
        cnt_next  = cnt + 1'b1;
      end
      tmtw_pkg::S_EXEC: begin
        case (cmd)
          tmtw_pkg::CMD_PUT: begin
            if (!is_nl) begin
              mem_we    = 1'b1;
              mem_waddr = tmtw_pkg::cell_addr(tmtw_pkg::phys_row(cur_row, top), cur_col);
              mem_wdata = {color, char_q};
            end
            if (wrap) begin
              cur_col_next = '0;
              if (last_row) begin
                // old top row becomes the new bottom row
                blank_row_next = top;
                cnt_next       = '0;
                if (top == tmtw_pkg::ROW_W'(tmtw_pkg::ROWS - 1)) begin
                  top_next = '0;
                end else begin
                  top_next = top + 1'b1;
                end
              end else begin
                cur_row_next = cur_row + 1'b1;
                emit         = 1'b1;
              end
            end else begin
              cur_col_next = cur_col + 1'b1;
              emit         = 1'b1;
            end
          end
          tmtw_pkg::CMD_READ: begin
            if (rd_ok) begin
              mem_raddr = tmtw_pkg::cell_addr(tmtw_pkg::phys_row(rrow, top), rcol);
            end
          end
          tmtw_pkg::CMD_CLEAR: begin
            cur_col_next = '0;
            cur_row_next = '0;
            top_next     = '0;
            cnt_next     = '0;
          end
          default: emit = 1'b1;
        endcase
      end
      tmtw_pkg::S_READ: emit = 1'b1;
      tmtw_pkg::S_FILL: begin
        mem_we   = 1'b1;
        cnt_next = cnt + 1'b1;
        emit     = fill_last;
      end
      tmtw_pkg::S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = tmtw_pkg::cell_addr(blank_row, cnt[tmtw_pkg::COL_W-1:0]);
        cnt_next  = cnt + 1'b1;
        emit      = blank_last;
      end
      default: ;
    endcase
  end

  // read data only reaches the result for an in-range read
  assign cell_val = (state == tmtw_pkg::S_READ && rd_ok) ? mem_rdata : 16'd0;

  // screen memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= cells[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tmtw_pkg::S_INIT;
      cnt       <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      top       <= '0;
      color     <= tmtw_pkg::RESET_COLOR;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      cur_col   <= cur_col_next;
      cur_row   <= cur_row_next;
      top       <= top_next;
      done      <= emit;
      if (text_color_we) begin
        color <= text_color;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    blank_row <= blank_row_next;
    if (accept) begin
      cmd    <= command;
      char_q <= char_code;
      rrow   <= read_row;
      rcol   <= read_col;
      rd_ok  <= (read_row < tmtw_pkg::ROW_W'(tmtw_pkg::ROWS)) &&
                (read_col < tmtw_pkg::COL_W'(tmtw_pkg::COLUMNS));
    end
    if (emit) begin
      cursor_col_out <= cur_col_next;
      cursor_row_out <= cur_row_next;
      cell_entry     <= cell_val;
    end
  end

endmodule
